FILE: rtl/edge_timed_uart_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edge-timed serial receiver
// Immediate-consequence and next-cycle checks on the clock clk, off under
// SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef EDGE_TIMED_UART_RECEIVER_ASSERT_SVH
`define EDGE_TIMED_UART_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define ETUR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etur check failed");

// Consequent must hold in the cycle after the antecedent
`define ETUR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etur check failed");

`else

`define ETUR_ASSERT_NOW(lbl, ante, cons)
`define ETUR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/etur_pkg.sv
// ----------------------------------------------------------------------------
// etur_pkg
// Shared types and constants of the edge-timed serial receiver.
// ----------------------------------------------------------------------------
package etur_pkg;

  // Field widths
  localparam int unsigned TS_W    = 32;
  localparam int unsigned BT_W    = 20;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned IDX_W   = 4;

  // Divider: one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = 5;

  // Frame geometry
  localparam logic [TS_W-1:0]  LAST_BIT      = TS_W'(9);
  localparam int unsigned      QUARTER_SHIFT = 2;
  localparam logic [BT_W-1:0]  BIT_TIME_RST  = BT_W'(8333);

  // Item actions
  localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

  // Commands from the control FSM to the FIFO
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_cmd_t;

  // FIFO status back to the control FSM
  typedef struct packed {
    logic              nonempty;
    logic              full;
    logic [FILL_W-1:0] fill;
  } fifo_stat_t;

endpackage

FILE: rtl/etur_div.sv
// ----------------------------------------------------------------------------
// etur_div
// Bit-serial restoring divider: 32-bit dividend by 20-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module etur_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [etur_pkg::TS_W-1:0]    dividend,
  input  logic [etur_pkg::BT_W-1:0]    divisor,
  output logic                         done,
  output logic [etur_pkg::TS_W-1:0]    quotient
);
  import etur_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [BT_W-1:0]      dvs;
  logic [BT_W-1:0]      rem;
  logic [TS_W-1:0]      quo;
  logic [BT_W:0]        trial;
  logic                 take;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, quo[TS_W-1]};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and combined dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= take ? BT_W'(trial - {1'b0, dvs}) : trial[BT_W-1:0];
      quo <= {quo[TS_W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/etur_fifo.sv
// ----------------------------------------------------------------------------
// etur_fifo
// Receive ring FIFO holding DEPTH-1 bytes, with a registered read port that
// always follows the read pointer.
// ----------------------------------------------------------------------------
module etur_fifo #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  etur_pkg::fifo_cmd_t           cmd,
  input  logic [etur_pkg::BYTE_W-1:0]   push_data,
  output logic [etur_pkg::BYTE_W-1:0]   rd_data,
  output etur_pkg::fifo_stat_t          stat
);
  import etur_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = (PTR_W + 1 > FILL_W) ? PTR_W + 1 : FILL_W;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rp_inc;
  logic [CNT_W-1:0]  diff;

  // Ring advance
  assign wp_inc = (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc = (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;

  // Status
  assign stat.nonempty = (wp != rp);
  assign stat.full     = (wp_inc == rp);
  always_comb begin
    diff = CNT_W'(wp) - CNT_W'(rp);
    if (wp < rp) begin
      diff = diff + CNT_W'(DEPTH);
    end
  end
  assign stat.fill = diff[FILL_W-1:0];

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else if (cmd.flush) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (cmd.push && !stat.full) begin
        wp <= wp_inc;
      end
      if (cmd.pop && stat.nonempty) begin
        rp <= rp_inc;
      end
    end
  end

  // Storage and registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.push && !stat.full) begin
      mem[wp] <= push_data;
    end
    rd_data <= mem[rp];
  end

endmodule

FILE: rtl/edge_timed_uart_receiver.sv
// Path: a read that removes a byte via S_POP, S_WAIT, S_HEAD; flush, unknown,
// empty-read, frame-opening items: S_WAIT, S_HEAD; other edges add S_DIV (32 steps).
// Throughput: one item at a time; the next is accepted once the result registers are loaded,
// even while that result still waits on the output.
// Reset (rst, synchronous): bit time 8333, frame state and FIFO pointers cleared, FIFO
// contents left as they are.
// ----------------------------------------------------------------------------
// edge_timed_uart_receiver
// Edge-timed 8N1 receiver: frames built from timed line edges, bytes kept in
// a ring FIFO, read and flush items served from it.
// ----------------------------------------------------------------------------
`include "edge_timed_uart_receiver_assert.svh"

module edge_timed_uart_receiver #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [etur_pkg::ACT_W-1:0]    action,
  input  logic                          line_level,
  input  logic [etur_pkg::TS_W-1:0]     timestamp,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [etur_pkg::BYTE_W-1:0]   read_byte,
  output logic                          read_valid,
  output logic [etur_pkg::BYTE_W-1:0]   head_byte,
  output logic                          head_valid,
  output logic [etur_pkg::FILL_W-1:0]   fill_count,
  output logic                          byte_stored,
  // bit time register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [etur_pkg::BT_W-1:0]     cfg_data
);
  import etur_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_HEAD = 3'd4;

  logic [2:0]         state;
  logic [BT_W-1:0]    bit_time;
  logic [TS_W-1:0]    frame_start_time;
  logic [FRAME_W-1:0] frame_bits;
  logic [IDX_W-1:0]   bit_index;

  // item payload and partial result
  logic               lvl_q;
  logic [TS_W-1:0]    ts_q;
  logic [BYTE_W-1:0]  res_rbyte;
  logic               res_rvalid;
  logic               res_stored;

  logic               accept;
  logic               frame_open;
  logic [BT_W-1:0]    bt_eff;
  logic [TS_W-1:0]    quarter;
  logic               div_start;
  logic               div_done;
  logic [TS_W-1:0]    n;
  logic               late_fall;
  logic               at_end;
  logic [FRAME_W-1:0] mask_nine;
  logic [FRAME_W-1:0] mask_n;
  logic [FRAME_W-1:0] bits_closed;
  logic [BYTE_W-1:0]  push_data;
  logic [BYTE_W-1:0]  rd_data;
  logic               out_load;
  fifo_cmd_t          cmd;
  fifo_stat_t         stat;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_HEAD) && (!out_valid || !out_stall);

  // Effective bit time and quarter-bit start offset
  assign bt_eff  = (bit_time == '0) ? BT_W'(1) : bit_time;
  assign quarter = TS_W'(bt_eff >> QUARTER_SHIFT);

  // Falling edge while idle opens a frame; any other edge needs the bit number
  assign frame_open = accept && (action == ACT_EDGE) && !line_level && (bit_index == '0);
  assign div_start  = accept && (action == ACT_EDGE) && !frame_open;

  etur_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timestamp - frame_start_time),
    .divisor  (bt_eff),
    .done     (div_done),
    .quotient (n)
  );

  // Edge decisions on the bit number
  assign late_fall = !lvl_q && (n > LAST_BIT);
  assign at_end    = (n >= LAST_BIT);

  // Fill masks: positions from bit_index up to nine, and up to below n
  always_comb begin
    for (int i = 0; i < FRAME_W; i++) begin
      mask_nine[i] = (IDX_W'(i) >= bit_index);
      mask_n[i]    = (IDX_W'(i) >= bit_index) && (IDX_W'(i) < n[IDX_W-1:0]);
    end
  end

  assign bits_closed = late_fall ? (frame_bits | mask_nine) : frame_bits;
  assign push_data   = bits_closed[BYTE_W:1];

  // FIFO commands
  always_comb begin
    cmd = '0;
    if (accept && action == ACT_FLUSH) begin
      cmd.flush = 1'b1;
    end
    if (state == S_POP) begin
      cmd.pop = 1'b1;
    end
    if (state == S_DIV && div_done && at_end) begin
      cmd.push = 1'b1;
    end
  end

  etur_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push_data (push_data),
    .rd_data   (rd_data),
    .stat      (stat)
  );

  // Bit time register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time <= BIT_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      bit_time <= cfg_data;
    end
  end

  // Control FSM and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      frame_start_time <= '0;
      frame_bits       <= '0;
      bit_index        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WAIT;
            if (action == ACT_EDGE) begin
              if (!line_level && bit_index == '0) begin
                frame_start_time <= timestamp - quarter;
                frame_bits       <= '0;
                bit_index        <= IDX_W'(1);
              end else begin
                state <= S_DIV;
              end
            end else if (action == ACT_READ && stat.nonempty) begin
              state <= S_POP;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WAIT;
            if (late_fall) begin
              // late falling edge closes the frame and opens the next
              frame_start_time <= ts_q - quarter;
              frame_bits       <= '0;
              bit_index        <= IDX_W'(1);
            end else if (at_end) begin
              frame_bits <= '0;
              bit_index  <= '0;
            end else begin
              if (!lvl_q) begin
                frame_bits <= frame_bits | mask_n;
              end
              bit_index <= n[IDX_W-1:0];
            end
          end
        end
        S_POP: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_HEAD;
        end
        S_HEAD: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload and partial result
  always_ff @(posedge clk) begin
    if (accept) begin
      lvl_q      <= line_level;
      ts_q       <= timestamp;
      res_rbyte  <= '0;
      res_rvalid <= 1'b0;
      res_stored <= 1'b0;
    end else begin
      if (state == S_POP) begin
        res_rbyte  <= rd_data;
        res_rvalid <= 1'b1;
      end
      if (cmd.push) begin
        res_stored <= !stat.full;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_byte   <= res_rbyte;
      read_valid  <= res_rvalid;
      head_byte   <= stat.nonempty ? rd_data : '0;
      head_valid  <= stat.nonempty;
      fill_count  <= stat.fill;
      byte_stored <= res_stored;
    end
  end

  // Checks
  `ETUR_ASSERT_NOW(a_div_done_in_div, div_done, state == S_DIV)
  `ETUR_ASSERT_NEXT(a_head_gives_result, out_load, out_valid && state == S_IDLE)
  `ETUR_ASSERT_NEXT(a_fall_opens_frame, frame_open, bit_index == IDX_W'(1))
  `ETUR_ASSERT_NOW(a_push_only_at_end, cmd.push, div_done && at_end)

endmodule

FILE: test/tb_edge_timed_uart_receiver.sv
// ----------------------------------------------------------------------------
// tb_edge_timed_uart_receiver
// Self-checking bench for the edge-timed serial receiver. A short table of
// directed items is run first, then random 8N1 frames built from timed edges,
// mixed with reads, flushes, stray edges and cut-short frames, over several
// bit times. Every item is predicted by a behavioural model of the framing
// logic and the ring FIFO, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_edge_timed_uart_receiver;
  import etur_pkg::*;

  localparam int unsigned FIFO_DEPTH     = 64;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned END_PAUSE      = 40;
  localparam int unsigned DIR_ROWS       = 25;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PRINT_CAP      = 50;

  // Action code the block ignores
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  // Timestamps used by the directed table
  localparam logic [TS_W-1:0] BT0 = TS_W'(BIT_TIME_RST);
  localparam logic [TS_W-1:0] TA  = 32'd100000;
  localparam logic [TS_W-1:0] TW  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic [BYTE_W-1:0] head_byte;
    logic              head_valid;
    logic [FILL_W-1:0] fill_count;
    logic              byte_stored;
  } rx_result_t;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic             lvl;
    logic [TS_W-1:0]  ts;
    bit               typed;
    rx_result_t       res;
  } rx_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action     = ACT_EDGE;
  logic                line_level = 1'b1;
  logic [TS_W-1:0]     timestamp  = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [BYTE_W-1:0]   read_byte;
  logic                read_valid;
  logic [BYTE_W-1:0]   head_byte;
  logic                head_valid;
  logic [FILL_W-1:0]   fill_count;
  logic                byte_stored;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [BT_W-1:0]     cfg_data   = '0;

  edge_timed_uart_receiver #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .line_level  (line_level),
    .timestamp   (timestamp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_byte   (read_byte),
    .read_valid  (read_valid),
    .head_byte   (head_byte),
    .head_valid  (head_valid),
    .fill_count  (fill_count),
    .byte_stored (byte_stored),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver model state
  logic [BT_W-1:0]    bit_time_q = BIT_TIME_RST;
  logic [TS_W-1:0]    frame_t0   = '0;
  logic [FRAME_W-1:0] frame_word = '0;
  logic [IDX_W-1:0]   bit_pos    = '0;
  logic [BYTE_W-1:0]  fifo_mem [FIFO_DEPTH];
  int unsigned        wr_ptr     = 0;
  int unsigned        rd_ptr     = 0;

  rx_result_t  pending_results [$];
  int unsigned err_cnt     = 0;
  int unsigned items_sent  = 0;
  int unsigned quiet_cycles = 0;
  bit          in_burst    = 1'b0;
  bit          out_burst   = 1'b0;
  bit          hold_req    = 1'b0;
  logic [TS_W-1:0] ts_now  = '0;

  // Directed items; a typed result only where it is obvious
  rx_item_t dir_tab [DIR_ROWS] = '{
    '{ACT_READ,  1'b0, 32'd0,               1'b1, '0}, // read while empty
    '{ACT_NONE,  1'b1, TW,                  1'b1, '0}, // unknown action
    '{ACT_FLUSH, 1'b0, 32'd0,               1'b1, '0}, // flush while empty
    '{ACT_EDGE,  1'b1, 32'd0,               1'b0, '0}, // high edge while idle
    '{ACT_EDGE,  1'b0, TA,                  1'b0, '0}, // frame open
    '{ACT_EDGE,  1'b1, 32'(TA + 9*BT0),     1'b0, '0}, // stop at bit nine: 0x00
    '{ACT_EDGE,  1'b0, 32'(TA + 20*BT0),    1'b0, '0},
    '{ACT_EDGE,  1'b1, 32'(TA + 21*BT0),    1'b0, '0},
    '{ACT_EDGE,  1'b0, 32'(TA + 40*BT0),    1'b0, '0}, // late fall: 0xFF, new frame
    '{ACT_EDGE,  1'b1, 32'(TA + 45*BT0),    1'b0, '0},
    '{ACT_EDGE,  1'b0, 32'(TA + 43*BT0),    1'b0, '0}, // bit number goes back
    '{ACT_EDGE,  1'b1, 32'(TA + 46*BT0),    1'b0, '0},
    '{ACT_EDGE,  1'b0, 32'(TA + 47*BT0),    1'b0, '0},
    '{ACT_EDGE,  1'b1, 32'(TA + 49*BT0),    1'b0, '0},
    '{ACT_READ,  1'b1, TW,                  1'b0, '0},
    '{ACT_READ,  1'b0, 32'd0,               1'b0, '0},
    '{ACT_READ,  1'b1, 32'h5555_5555,       1'b0, '0},
    '{ACT_READ,  1'b0, 32'hAAAA_AAAA,       1'b0, '0}, // empty again
    '{ACT_EDGE,  1'b0, TW,                  1'b0, '0}, // frame across the wrap
    '{ACT_EDGE,  1'b1, 32'(TW + 2*BT0),     1'b0, '0},
    '{ACT_EDGE,  1'b0, 32'(TW + 5*BT0),     1'b0, '0},
    '{ACT_EDGE,  1'b1, 32'(TW + 9*BT0),     1'b0, '0},
    '{ACT_FLUSH, 1'b1, TW,                  1'b1, '0}, // flush with data held
    '{ACT_EDGE,  1'b0, 32'd0,               1'b0, '0},
    '{ACT_EDGE,  1'b1, TW,                  1'b0, '0}
  };

  // Store the finished frame unless the FIFO is full
  function automatic logic push_byte();
    int unsigned nxt;
    nxt = (wr_ptr + 1) % FIFO_DEPTH;
    if (nxt == rd_ptr) return 1'b0;
    fifo_mem[wr_ptr] = frame_word[8:1];
    wr_ptr = nxt;
    return 1'b1;
  endfunction

  // Expected result of one item; advances the model state
  function automatic rx_result_t decode_item(input logic [ACT_W-1:0] act, input logic lvl,
                                             input logic [TS_W-1:0] ts);
    rx_result_t      r;
    logic [TS_W-1:0] bt;
    logic [TS_W-1:0] quarter;
    logic [TS_W-1:0] bit_no;
    logic            stored;
    int              i;
    r      = '0;
    stored = 1'b0;
    bt      = (bit_time_q == '0) ? TS_W'(1) : TS_W'(bit_time_q);
    quarter = bt >> QUARTER_SHIFT;
    case (act)
      ACT_EDGE: begin
        if (!lvl && bit_pos == '0) begin
          frame_t0   = ts - quarter;
          frame_word = '0;
          bit_pos    = IDX_W'(1);
        end else begin
          bit_no = (ts - frame_t0) / bt;
          if (!lvl && bit_no > LAST_BIT) begin
            // late falling edge: rest of frame was high, next frame starts here
            for (i = int'(bit_pos); i <= int'(LAST_BIT); i++) frame_word[i] = 1'b1;
            stored     = push_byte();
            frame_t0   = ts - quarter;
            frame_word = '0;
            bit_pos    = IDX_W'(1);
          end else if (bit_no >= LAST_BIT) begin
            stored     = push_byte();
            frame_word = '0;
            bit_pos    = '0;
          end else begin
            if (!lvl) begin
              for (i = int'(bit_pos); i < int'(bit_no); i++) frame_word[i] = 1'b1;
            end
            bit_pos = bit_no[IDX_W-1:0];
          end
        end
      end
      ACT_READ: begin
        if (wr_ptr != rd_ptr) begin
          r.read_byte  = fifo_mem[rd_ptr];
          r.read_valid = 1'b1;
          rd_ptr       = (rd_ptr + 1) % FIFO_DEPTH;
        end
      end
      ACT_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
      end
      default: ;
    endcase
    r.head_valid  = (wr_ptr != rd_ptr);
    r.head_byte   = r.head_valid ? fifo_mem[rd_ptr] : '0;
    r.fill_count  = FILL_W'((wr_ptr + FIFO_DEPTH - rd_ptr) % FIFO_DEPTH);
    r.byte_stored = stored;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < PRINT_CAP)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // Offer one item after a random gap; predict it once taken
  task automatic drive_item(input rx_item_t it);
    int unsigned gap;
    rx_result_t  pred;
    if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= it.act;
    line_level <= it.lvl;
    timestamp  <= it.ts;
    do @(posedge clk); while (in_stall);
    pred = decode_item(it.act, it.lvl, it.ts);
    pending_results.push_back(it.typed ? it.res : pred);
    if (it.act != ACT_NONE) items_sent++;
  endtask

  task automatic send(input logic [ACT_W-1:0] act, input logic lvl,
                      input logic [TS_W-1:0] ts);
    rx_item_t it;
    it = '{act, lvl, ts, 1'b0, '0};
    drive_item(it);
  endtask

  // One 8N1 frame as timed edges, sometimes cut short, reads mixed in
  task automatic send_frame(input logic [BYTE_W-1:0] data, input int unsigned rd_pct);
    logic [FRAME_W-1:0] lv;
    logic [TS_W-1:0]    t0;
    logic [TS_W-1:0]    bt;
    logic [TS_W-1:0]    jit;
    int unsigned        cut;
    int unsigned        emitted;
    int unsigned        k;
    bt  = (bit_time_q == '0) ? TS_W'(1) : TS_W'(bit_time_q);
    jit = bt >> 3;
    lv  = {1'b1, data, 1'b0};
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 99;
    t0  = ts_now;
    send(ACT_EDGE, 1'b0, t0);
    emitted = 1;
    for (k = 1; k <= 9 && emitted < cut; k++) begin
      if (lv[k] != lv[k-1]) begin
        send(ACT_EDGE, lv[k], t0 + k*bt + $urandom_range(0, 2*jit) - jit);
        emitted++;
        if ($urandom_range(0, 99) < rd_pct / 3)
          send(ACT_READ, 1'($urandom_range(0, 1)), $urandom());
      end
    end
    // idle line before the next frame, sometimes none at all
    ts_now = t0 + 10*bt + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4*bt));
  endtask

  // Random traffic: mostly frames, plus reads, flushes, strays and junk actions
  task automatic gen_phase(input int unsigned n_items, input int unsigned rd_pct,
                           input int unsigned fl_pct);
    int unsigned start;
    int unsigned pick;
    start  = items_sent;
    ts_now = $urandom();
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < rd_pct)
        send(ACT_READ, 1'($urandom_range(0, 1)), $urandom());
      else if (pick < rd_pct + fl_pct)
        send(ACT_FLUSH, 1'($urandom_range(0, 1)), $urandom());
      else if (pick < rd_pct + fl_pct + 2)
        send(ACT_NONE, 1'($urandom_range(0, 1)), $urandom());
      else if (pick < rd_pct + fl_pct + 8)
        send(ACT_EDGE, 1'($urandom_range(0, 1)), $urandom());
      else
        send_frame(8'($urandom()), rd_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_bit_time(input logic [BT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    bit_time_q  = value;
  endtask

  // Result side: random stall after each item, one long hold on request
  initial begin : result_sink
    int unsigned wait_n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
        wait_n = out_burst ? 0 : $urandom_range(0, 6);
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(fill_count), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (read_byte !== want.read_byte)
          report_mismatch("read_byte", 32'(read_byte), 32'(want.read_byte));
        if (read_valid !== want.read_valid)
          report_mismatch("read_valid", 32'(read_valid), 32'(want.read_valid));
        if (head_byte !== want.head_byte)
          report_mismatch("head_byte", 32'(head_byte), 32'(want.head_byte));
        if (head_valid !== want.head_valid)
          report_mismatch("head_valid", 32'(head_valid), 32'(want.head_valid));
        if (fill_count !== want.fill_count)
          report_mismatch("fill_count", 32'(fill_count), 32'(want.fill_count));
        if (byte_stored !== want.byte_stored)
          report_mismatch("byte_stored", 32'(byte_stored), 32'(want.byte_stored));
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [BT_W-1:0] plan_bt    [PHASES];
    int unsigned     plan_items [PHASES];
    int unsigned     plan_rd    [PHASES];
    int unsigned     plan_fl    [PHASES];
    int unsigned     p;
    plan_bt    = '{20'd1, 20'd0, 20'hFFFFF, BT_W'($urandom_range(4, 300)),
                   BT_W'($urandom_range(1000, 200000)), BIT_TIME_RST};
    plan_items = '{120, 80, 120, 500, 150, 100};
    plan_rd    = '{15, 15, 10, 0, 30, 15};
    plan_fl    = '{2, 2, 2, 0, 2, 2};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset bit time
    foreach (dir_tab[r]) drive_item(dir_tab[r]);
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      write_bit_time(plan_bt[p]);
      // no reads here, so the FIFO fills; results held back for a while
      if (plan_rd[p] == 0) hold_req = 1'b1;
      gen_phase(plan_items[p], plan_rd[p], plan_fl[p]);
      drain_results();
    end

    repeat (END_PAUSE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", 32'd0, 32'(pending_results.size()));
    if (err_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
